// File: hdl/ebc_pkg.sv
// ----------------------------------------------------------------------------
// ebc_pkg: shared types, codes and helpers
// Opcodes, bus codes and sequencer steps, plus register-pair access helpers.
// ----------------------------------------------------------------------------
package ebc_pkg;

  // bus operation codes
  localparam logic [1:0] BUS_RD   = 2'd0;
  localparam logic [1:0] BUS_WR   = 2'd1;
  localparam logic [1:0] BUS_HALT = 2'd2;

  // config port
  localparam int unsigned PADDR_W = 2;
  localparam logic [PADDR_W-1:0] REG_START_ADDR = 2'd0;

  // sequencer steps
  localparam logic [3:0] ST_OPC = 4'd0;
  localparam logic [3:0] ST_OPND = 4'd1;
  localparam logic [3:0] ST_LO  = 4'd2;
  localparam logic [3:0] ST_HI  = 4'd3;
  localparam logic [3:0] ST_MLO = 4'd4;
  localparam logic [3:0] ST_MHI = 4'd5;

  // opcodes
  localparam logic [7:0] OP_HALT     = 8'h00;
  localparam logic [7:0] OP_MOV_RR   = 8'h10;
  localparam logic [7:0] OP_MOV_PP   = 8'h11;
  localparam logic [7:0] OP_MOV_RI   = 8'h12;
  localparam logic [7:0] OP_MOV_PI   = 8'h13;
  localparam logic [7:0] OP_MOV_RM   = 8'h14;
  localparam logic [7:0] OP_MOV_PM   = 8'h15;
  localparam logic [7:0] OP_RSVD_A   = 8'h16;
  localparam logic [7:0] OP_LD_RA    = 8'h17;
  localparam logic [7:0] OP_LD_PA    = 8'h18;
  localparam logic [7:0] OP_ST_PR    = 8'h19;
  localparam logic [7:0] OP_ST_PP    = 8'h1A;
  localparam logic [7:0] OP_ST_PI    = 8'h1B;
  localparam logic [7:0] OP_ST_PW    = 8'h1C;
  localparam logic [7:0] OP_JMP      = 8'h20;
  localparam logic [7:0] OP_JMP_IND  = 8'h21;
  localparam logic [7:0] OP_JMP_P    = 8'h22;
  localparam logic [7:0] OP_JMP_PM   = 8'h23;
  localparam logic [7:0] OP_CALL     = 8'h24;
  localparam logic [7:0] OP_CALL_IND = 8'h25;
  localparam logic [7:0] OP_CALL_P   = 8'h26;
  localparam logic [7:0] OP_CALL_PM  = 8'h27;
  localparam logic [7:0] OP_JZ       = 8'h28;
  localparam logic [7:0] OP_JNZ      = 8'h29;
  localparam logic [7:0] OP_JS       = 8'h2A;
  localparam logic [7:0] OP_JNS      = 8'h2B;
  localparam logic [7:0] OP_JC       = 8'h2C;
  localparam logic [7:0] OP_JNC      = 8'h2D;
  localparam logic [7:0] OP_RET      = 8'h2E;
  localparam logic [7:0] OP_CMP      = 8'h40;
  localparam logic [7:0] OP_CMPI     = 8'h41;
  localparam logic [7:0] OP_PCMP     = 8'h42;
  localparam logic [7:0] OP_ADD      = 8'h43;
  localparam logic [7:0] OP_SUB      = 8'h44;
  localparam logic [7:0] OP_MUL      = 8'h45;
  localparam logic [7:0] OP_DIV      = 8'h46;
  localparam logic [7:0] OP_PADD     = 8'h47;
  localparam logic [7:0] OP_PSUB     = 8'h48;
  localparam logic [7:0] OP_AND      = 8'h49;
  localparam logic [7:0] OP_OR       = 8'h4A;
  localparam logic [7:0] OP_XOR      = 8'h4B;
  localparam logic [7:0] OP_RSVD_B   = 8'h4C;
  localparam logic [7:0] OP_ICMP     = 8'h4D;
  localparam logic [7:0] OP_ICMPI    = 8'h4E;
  localparam logic [7:0] OP_ICMP_P   = 8'h4F;
  localparam logic [7:0] OP_SETZ     = 8'h50;
  localparam logic [7:0] OP_CLRZ     = 8'h51;
  localparam logic [7:0] OP_SETS     = 8'h52;
  localparam logic [7:0] OP_CLRS     = 8'h53;
  localparam logic [7:0] OP_SETC     = 8'h54;
  localparam logic [7:0] OP_CLRC     = 8'h55;
  localparam logic [7:0] OP_INC      = 8'h60;
  localparam logic [7:0] OP_PINC     = 8'h61;
  localparam logic [7:0] OP_DEC      = 8'h62;
  localparam logic [7:0] OP_PDEC     = 8'h63;
  localparam logic [7:0] OP_SHL      = 8'h64;
  localparam logic [7:0] OP_PSHL     = 8'h65;
  localparam logic [7:0] OP_SHR      = 8'h66;
  localparam logic [7:0] OP_PSHR     = 8'h67;
  localparam logic [7:0] OP_SHLR     = 8'h68;
  localparam logic [7:0] OP_PSHLR    = 8'h69;
  localparam logic [7:0] OP_SHRR     = 8'h6A;
  localparam logic [7:0] OP_PSHRR    = 8'h6B;

  // register file: A..H plus stack pointer
  typedef struct packed {
    logic [7:0][7:0] g;
    logic [15:0]     sp;
  } arch_t;

  function automatic logic [15:0] pair_get(arch_t a, logic [1:0] p);
    logic [15:0] v;
    if (p == 2'd3) begin
      v = a.sp;
    end else begin
      v = {a.g[{p, 1'b0}], a.g[{p, 1'b1}]};
    end
    return v;
  endfunction

  function automatic arch_t pair_set(arch_t a, logic [1:0] p, logic [15:0] v);
    arch_t r;
    r = a;
    if (p == 2'd3) begin
      r.sp = v;
    end else begin
      r.g[{p, 1'b0}] = v[15:8];
      r.g[{p, 1'b1}] = v[7:0];
    end
    return r;
  endfunction

  function automatic logic valid_op(logic [7:0] o);
    logic ok;
    ok = (o == OP_HALT)
      || (o >= OP_MOV_RR && o <= OP_ST_PW && o != OP_RSVD_A)
      || (o >= OP_JMP && o <= OP_RET)
      || (o >= OP_CMP && o <= OP_ICMP_P && o != OP_RSVD_B)
      || (o >= OP_SETZ && o <= OP_CLRC)
      || (o >= OP_INC && o <= OP_PSHRR);
    return ok;
  endfunction

endpackage

// File: hdl/ebc_if.sv
// ----------------------------------------------------------------------------
// ebc_if: transaction channels
// Input channel (command / read byte) and result channel (bus request).
// ----------------------------------------------------------------------------
interface ebc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] read_data;
  modport source (output valid, cmd, read_data, input ready);
  modport sink   (input valid, cmd, read_data, output ready);
endinterface

interface ebc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bus_op;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic        is_halted;
  logic        last;
  modport source (output valid, bus_op, bus_address, write_data, is_halted, last,
                  input ready);
  modport sink   (input valid, bus_op, bus_address, write_data, is_halted, last,
                  output ready);
endinterface

// File: hdl/eight_bit_cpu_bus_core_top.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_bus_core_top: 8-bit CPU core on an external byte bus
// Takes start commands and read bytes, returns bus requests (writes, then a read or halt).
// ----------------------------------------------------------------------------
// Flow: an accepted transaction is registered, executed in S_CALC (DIV also runs
//   the divider in S_DIV), then its results leave one per cycle while the output
//   is ready; the input is not ready until all results of a transaction are
//   taken.
// Reset (rst_n, synchronous): registers, SP, flags, halt and sequencer cleared,
//   PC and start_address set to zero.
module eight_bit_cpu_bus_core_top (
  input  logic                        clk,
  input  logic                        rst_n,
  ebc_in_if.sink                      in_ch,
  ebc_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ebc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ebc_pkg::*;

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } fsm_t;

  fsm_t state_r, state_nxt;

  // architectural state
  arch_t       arch_r, arch_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic        zf_r, zf_nxt, sf_r, sf_nxt, cf_r, cf_nxt, hm_r, hm_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [7:0]  opl_r, opl_nxt, opr_r, opr_nxt;
  logic [15:0] wl_r, wl_nxt;
  logic [15:0] start_r;

  // captured input transaction
  logic        cmd_r;
  logic [7:0]  byte_r;

  // result buffer (up to two writes and one read or halt)
  logic [1:0]  res_op_r   [3];
  logic [15:0] res_addr_r [3];
  logic [7:0]  res_data_r [3];
  logic [1:0]  res_cnt_r;
  logic [1:0]  res_idx_r;
  logic [1:0]  r_op   [3];
  logic [15:0] r_addr [3];
  logic [7:0]  r_data [3];
  logic [1:0]  r_n;

  logic        need_div;
  logic        div_done;
  logic [7:0]  div_q;
  logic        commit;
  logic        in_fire, out_fire;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_START_ADDR) ? {16'd0, start_r} : 32'd0;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // DIV is the only instruction that needs the multi-cycle unit; it executes
  // when its operand byte arrives
  assign need_div = cmd_r && !hm_r && (step_r == ST_OPND) && (opl_r == OP_DIV);
  assign commit   = ((state_r == S_CALC) && !need_div) || ((state_r == S_DIV) && div_done);

  ebc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == S_CALC) && need_div),
    .dividend (arch_r.g[byte_r[7:5]]),
    .divisor  (arch_r.g[byte_r[4:2]]),
    .done     (div_done),
    .quotient (div_q)
  );

  // one step of the instruction sequencer, evaluated at commit
  always_comb begin : step_calc
    arch_t       a;
    logic [15:0] pc, wl, val, addr, w, v;
    logic [7:0]  opl, opr, x, y;
    logic [15:0] prod;
    logic [3:0]  st;
    logic        zf, sf, cf, hm, exe;
    logic [1:0]  n, pd, ps;
    logic [2:0]  rd, rs, prs;

    a = arch_r; pc = pc_r; wl = wl_r; opl = opl_r; opr = opr_r; st = step_r;
    zf = zf_r; sf = sf_r; cf = cf_r; hm = hm_r;
    exe = 1'b0; val = 16'd0; n = 2'd0;
    addr = 16'd0; w = 16'd0; v = 16'd0; x = 8'd0; y = 8'd0; prod = 16'd0;
    pd = 2'd0; ps = 2'd0; rd = 3'd0; rs = 3'd0; prs = 3'd0;
    for (int i = 0; i < 3; i++) begin
      r_op[i] = BUS_RD; r_addr[i] = 16'd0; r_data[i] = 8'd0;
    end

    if (!cmd_r) begin
      // start: abandon current instruction, fetch from start address
      hm = 1'b0; pc = start_r; st = ST_OPC;
      r_op[n] = BUS_RD; r_addr[n] = pc; n = n + 2'd1;
    end else if (hm) begin
      r_op[n] = BUS_HALT; r_addr[n] = pc; n = n + 2'd1;
    end else begin
      case (st)
        ST_OPND: begin
          opr = byte_r; pc = pc + 16'd1;
          if (opl inside {OP_MOV_RI, OP_MOV_PI, OP_LD_RA, OP_LD_PA, OP_ST_PI, OP_ST_PW,
                          OP_CMPI, OP_ICMPI}) begin
            st = ST_LO; r_op[n] = BUS_RD; r_addr[n] = pc; n = n + 2'd1;
          end else if (opl inside {OP_MOV_RM, OP_MOV_PM, OP_JMP_PM, OP_CALL_PM}) begin
            if (opl == OP_CALL_PM) begin
              a.sp = a.sp - 16'd2;
              r_op[n] = BUS_WR; r_addr[n] = a.sp; r_data[n] = pc[7:0]; n = n + 2'd1;
              r_op[n] = BUS_WR; r_addr[n] = a.sp + 16'd1; r_data[n] = pc[15:8];
              n = n + 2'd1;
            end
            if (opl == OP_MOV_RM) begin
              wl = pair_get(a, byte_r[4:3]);
            end else if (opl == OP_MOV_PM) begin
              wl = pair_get(a, byte_r[5:4]);
            end else begin
              wl = pair_get(a, byte_r[7:6]);
            end
            st = ST_MLO; r_op[n] = BUS_RD; r_addr[n] = wl; n = n + 2'd1;
          end else begin
            exe = 1'b1;
          end
        end
        ST_LO: begin
          pc = pc + 16'd1; wl = {8'd0, byte_r};
          if (opl inside {OP_MOV_RI, OP_ST_PI, OP_CMPI, OP_ICMPI}) begin
            exe = 1'b1; val = {8'd0, byte_r};
          end else begin
            st = ST_HI; r_op[n] = BUS_RD; r_addr[n] = pc; n = n + 2'd1;
          end
        end
        ST_HI: begin
          pc = pc + 16'd1; wl = {byte_r, wl[7:0]};
          if (opl inside {OP_LD_RA, OP_LD_PA, OP_JMP_IND, OP_CALL_IND}) begin
            st = ST_MLO; r_op[n] = BUS_RD; r_addr[n] = wl; n = n + 2'd1;
          end else begin
            exe = 1'b1; val = wl;
          end
        end
        ST_MLO: begin
          if (opl == OP_MOV_RM || opl == OP_LD_RA) begin
            exe = 1'b1; val = {8'd0, byte_r};
          end else begin
            addr = wl + 16'd1; wl = {8'd0, byte_r};
            st = ST_MHI; r_op[n] = BUS_RD; r_addr[n] = addr; n = n + 2'd1;
          end
        end
        ST_MHI: begin
          exe = 1'b1; val = {byte_r, wl[7:0]};
        end
        default: begin
          // opcode fetch; unused step codes land here too
          opl = byte_r; pc = pc + 16'd1;
          if (byte_r == OP_HALT || !valid_op(byte_r)) begin
            hm = 1'b1; st = ST_OPC;
            r_op[n] = BUS_HALT; r_addr[n] = pc; n = n + 2'd1;
          end else if (byte_r >= OP_SETZ && byte_r <= OP_CLRC) begin
            exe = 1'b1;
          end else if (byte_r == OP_RET) begin
            wl = a.sp; st = ST_MLO; r_op[n] = BUS_RD; r_addr[n] = wl; n = n + 2'd1;
          end else if (byte_r inside {OP_JMP, OP_JMP_IND, OP_CALL, OP_CALL_IND,
                                      [OP_JZ:OP_JNC]}) begin
            st = ST_LO; r_op[n] = BUS_RD; r_addr[n] = pc; n = n + 2'd1;
          end else begin
            st = ST_OPND; r_op[n] = BUS_RD; r_addr[n] = pc; n = n + 2'd1;
          end
        end
      endcase

      if (exe) begin
        pd = opr[7:6]; ps = opr[5:4]; rd = opr[7:5]; rs = opr[4:2]; prs = opr[5:3];
        case (opl)
          OP_MOV_RR: begin
            x = a.g[rs]; zf = (x == 8'd0); sf = x[7]; a.g[rd] = x;
          end
          OP_MOV_PP: begin
            w = pair_get(a, ps); zf = (w == 16'd0); sf = w[15]; a = pair_set(a, pd, w);
          end
          OP_MOV_RI, OP_LD_RA, OP_MOV_RM: begin
            x = val[7:0]; zf = (x == 8'd0); sf = x[7]; a.g[rd] = x;
          end
          OP_MOV_PI, OP_MOV_PM, OP_LD_PA: begin
            zf = (val == 16'd0); sf = val[15]; a = pair_set(a, pd, val);
          end
          OP_ST_PR, OP_ST_PI: begin
            x = (opl == OP_ST_PR) ? a.g[prs] : val[7:0];
            zf = (x == 8'd0); sf = x[7];
            r_op[n] = BUS_WR; r_addr[n] = pair_get(a, pd); r_data[n] = x; n = n + 2'd1;
          end
          OP_ST_PP, OP_ST_PW: begin
            w = (opl == OP_ST_PP) ? pair_get(a, ps) : val;
            zf = (w == 16'd0); sf = w[15];
            addr = pair_get(a, pd);
            r_op[n] = BUS_WR; r_addr[n] = addr; r_data[n] = w[7:0]; n = n + 2'd1;
            r_op[n] = BUS_WR; r_addr[n] = addr + 16'd1; r_data[n] = w[15:8]; n = n + 2'd1;
          end
          OP_JMP, OP_JMP_IND, OP_JMP_PM, OP_CALL_PM: pc = val;
          OP_JMP_P: pc = pair_get(a, pd);
          OP_CALL, OP_CALL_IND, OP_CALL_P: begin
            a.sp = a.sp - 16'd2;
            r_op[n] = BUS_WR; r_addr[n] = a.sp; r_data[n] = pc[7:0]; n = n + 2'd1;
            r_op[n] = BUS_WR; r_addr[n] = a.sp + 16'd1; r_data[n] = pc[15:8]; n = n + 2'd1;
            pc = (opl == OP_CALL_P) ? pair_get(a, pd) : val;
          end
          OP_JZ:  if (zf)  pc = val;
          OP_JNZ: if (!zf) pc = val;
          OP_JS:  if (sf)  pc = val;
          OP_JNS: if (!sf) pc = val;
          OP_JC:  if (cf)  pc = val;
          OP_JNC: if (!cf) pc = val;
          OP_RET: begin
            pc = val; a.sp = a.sp + 16'd2;
          end
          OP_CMP, OP_CMPI: begin
            x = a.g[rd]; y = (opl == OP_CMP) ? a.g[rs] : val[7:0];
            zf = (x == y); sf = (x < y); cf = (x > y);
          end
          OP_ICMP, OP_ICMPI: begin
            x = a.g[rd]; y = (opl == OP_ICMP) ? a.g[rs] : val[7:0];
            zf = (x == y); sf = ($signed(x) < $signed(y)); cf = ($signed(x) > $signed(y));
          end
          OP_PCMP: begin
            w = pair_get(a, pd); v = pair_get(a, ps);
            zf = (w == v); sf = (w < v); cf = (w > v);
          end
          OP_ICMP_P: begin
            w = pair_get(a, pd); v = pair_get(a, ps);
            zf = (w == v); sf = ($signed(w) < $signed(v)); cf = ($signed(w) > $signed(v));
          end
          OP_ADD: a.g[rd] = a.g[rd] + a.g[rs];
          OP_SUB: a.g[rd] = a.g[rd] - a.g[rs];
          OP_MUL: begin
            prod = 16'(a.g[rd]) * 16'(a.g[rs]); a.g[rd] = prod[7:0];
          end
          OP_DIV: a.g[rd] = div_q;
          OP_AND: a.g[rd] = a.g[rd] & a.g[rs];
          OP_OR:  a.g[rd] = a.g[rd] | a.g[rs];
          OP_XOR: a.g[rd] = a.g[rd] ^ a.g[rs];
          OP_PADD: a = pair_set(a, pd, pair_get(a, pd) + {8'd0, a.g[prs]});
          OP_PSUB: a = pair_set(a, pd, pair_get(a, pd) - {8'd0, a.g[prs]});
          OP_SETZ: zf = 1'b1;
          OP_CLRZ: zf = 1'b0;
          OP_SETS: sf = 1'b1;
          OP_CLRS: sf = 1'b0;
          OP_SETC: cf = 1'b1;
          OP_CLRC: cf = 1'b0;
          OP_INC: begin
            x = a.g[rd]; zf = (x == 8'hFF); cf = zf; a.g[rd] = x + 8'd1;
          end
          OP_PINC: begin
            w = pair_get(a, pd); zf = (w == 16'hFFFF); cf = zf;
            a = pair_set(a, pd, w + 16'd1);
          end
          OP_DEC: begin
            x = a.g[rd]; zf = (x == 8'd1); cf = (x == 8'd0); a.g[rd] = x - 8'd1;
          end
          OP_PDEC: begin
            w = pair_get(a, pd); zf = (w == 16'd1); cf = (w == 16'd0);
            a = pair_set(a, pd, w - 16'd1);
          end
          OP_SHL: a.g[rd] = (opr[3]) ? 8'd0 : (a.g[rd] << opr[2:0]);
          OP_SHR: a.g[rd] = (opr[3]) ? 8'd0 : (a.g[rd] >> opr[2:0]);
          OP_PSHL: a = pair_set(a, pd, pair_get(a, pd) << opr[3:0]);
          OP_PSHR: a = pair_set(a, pd, pair_get(a, pd) >> opr[3:0]);
          OP_SHLR, OP_SHRR: begin
            y = a.g[rs];
            if (y >= 8'd8) begin
              a.g[rd] = 8'd0;
            end else if (opl == OP_SHLR) begin
              a.g[rd] = a.g[rd] << y[2:0];
            end else begin
              a.g[rd] = a.g[rd] >> y[2:0];
            end
          end
          OP_PSHLR, OP_PSHRR: begin
            v = pair_get(a, ps);
            w = pair_get(a, pd);
            if (v >= 16'd16) begin
              w = 16'd0;
            end else if (opl == OP_PSHLR) begin
              w = w << v[3:0];
            end else begin
              w = w >> v[3:0];
            end
            a = pair_set(a, pd, w);
          end
          default: ;
        endcase
        st = ST_OPC;
        r_op[n] = BUS_RD; r_addr[n] = pc; n = n + 2'd1;
      end
    end

    arch_nxt = a; pc_nxt = pc; wl_nxt = wl; opl_nxt = opl; opr_nxt = opr;
    step_nxt = st; zf_nxt = zf; sf_nxt = sf; cf_nxt = cf; hm_nxt = hm;
    r_n = n;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_CALC;
      S_CALC: state_nxt = need_div ? S_DIV : S_OUT;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (out_fire && (res_idx_r == res_cnt_r - 2'd1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      arch_r    <= '0;
      pc_r      <= 16'd0;
      start_r   <= 16'd0;
      zf_r      <= 1'b0;
      sf_r      <= 1'b0;
      cf_r      <= 1'b0;
      hm_r      <= 1'b0;
      step_r    <= ST_OPC;
      opl_r     <= 8'd0;
      opr_r     <= 8'd0;
      wl_r      <= 16'd0;
      res_cnt_r <= 2'd0;
      res_idx_r <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (psel && penable && pwrite && (paddr == REG_START_ADDR)) begin
        start_r <= pwdata[15:0];
      end
      if (commit) begin
        arch_r    <= arch_nxt;
        pc_r      <= pc_nxt;
        zf_r      <= zf_nxt;
        sf_r      <= sf_nxt;
        cf_r      <= cf_nxt;
        hm_r      <= hm_nxt;
        step_r    <= step_nxt;
        opl_r     <= opl_nxt;
        opr_r     <= opr_nxt;
        wl_r      <= wl_nxt;
        res_cnt_r <= r_n;
        res_idx_r <= 2'd0;
      end else if (out_fire) begin
        res_idx_r <= res_idx_r + 2'd1;
      end
    end
    if (in_fire) begin
      cmd_r  <= in_ch.cmd;
      byte_r <= in_ch.read_data;
    end
    if (commit) begin
      res_op_r   <= r_op;
      res_addr_r <= r_addr;
      res_data_r <= r_data;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.bus_op      = res_op_r[res_idx_r];
  assign out_ch.bus_address = res_addr_r[res_idx_r];
  assign out_ch.write_data  = res_data_r[res_idx_r];
  assign out_ch.is_halted   = (res_op_r[res_idx_r] == BUS_HALT);
  assign out_ch.last        = (res_idx_r == res_cnt_r - 2'd1);
endmodule

// File: hdl/ebc_div.sv
// ----------------------------------------------------------------------------
// ebc_div: iterative 8-bit divider
// Restoring division, one quotient bit per cycle; zero divisor gives 0xFF.
// ----------------------------------------------------------------------------
module ebc_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic       done,
  output logic [7:0] quotient
);
  logic [7:0] q_r, q_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] d_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic [8:0] rem_sh;
  logic [8:0] rem_sub;

  assign rem_sh  = {rem_r, q_r[7]};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = 8'd0;
      cnt_nxt  = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = rem_sub[7:0];
        q_nxt   = {q_r[6:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[7:0];
        q_nxt   = {q_r[6:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign done     = busy_r && (cnt_r == 4'd7);
  assign quotient = q_nxt;
endmodule
